/* sv/dsfp_pkg.sv */
// ----------------------------------------------------------------------------
// dsfp_pkg
// Shared types, constants and the status class lookup for the dispenser
// status frame parser.
// ----------------------------------------------------------------------------
package dsfp_pkg;

  localparam logic [3:0] FRAME_LEN = 4'd8;

  localparam logic [7:0] CH_S   = 8'h53;
  localparam logic [7:0] CH_F   = 8'h46;
  localparam logic [7:0] CH_ETX = 8'h03;

  localparam logic [2:0] POS_S    = 3'd1;
  localparam logic [2:0] POS_F    = 3'd2;
  localparam logic [2:0] POS_ST0  = 3'd3;
  localparam logic [2:0] POS_ST2  = 3'd5;
  localparam logic [2:0] POS_ETX  = 3'd6;
  localparam logic [2:0] POS_CHK  = 3'd7;

  localparam logic [3:0] CLS_READY     = 4'd0;
  localparam logic [3:0] CLS_LOW_CARD  = 4'd1;
  localparam logic [3:0] CLS_BIN_FULL  = 4'd2;
  localparam logic [3:0] CLS_EMPTY     = 4'd3;
  localparam logic [3:0] CLS_AT_EXIT   = 4'd4;
  localparam logic [3:0] CLS_IN_READER = 4'd5;
  localparam logic [3:0] CLS_NOT_READY = 4'd6;
  localparam logic [3:0] CLS_BLOCKED   = 4'd7;
  localparam logic [3:0] CLS_ISSUING   = 4'd8;
  localparam logic [3:0] CLS_ISSUE_ERR = 4'd9;
  localparam logic [3:0] CLS_RETURNING = 4'd10;
  localparam logic [3:0] CLS_BAD       = 4'd11;

  typedef struct packed {
    logic        ok;
    logic [23:0] word;
  } frame_sum_t;

  function automatic logic [3:0] class_of(input logic [23:0] w);
    logic [3:0] c;
    case (w)
      24'h303030: c = CLS_READY;
      24'h303130: c = CLS_LOW_CARD;
      24'h303430: c = CLS_LOW_CARD;
      24'h313030: c = CLS_BIN_FULL;
      24'h303830: c = CLS_BIN_FULL;
      24'h303038: c = CLS_EMPTY;
      24'h303034: c = CLS_AT_EXIT;
      24'h303032: c = CLS_IN_READER;
      24'h303031: c = CLS_NOT_READY;
      24'h303230: c = CLS_BLOCKED;
      24'h383030: c = CLS_ISSUING;
      24'h323030: c = CLS_ISSUE_ERR;
      24'h343030: c = CLS_RETURNING;
      default:    c = CLS_BAD;
    endcase
    return c;
  endfunction

endpackage

/* sv/dsfp_accum.sv */
// ----------------------------------------------------------------------------
// dsfp_accum
// Per-byte frame state: byte count, running XOR, header and check flags,
// status bytes. Gives the frame summary for the byte being consumed.
// ----------------------------------------------------------------------------
module dsfp_accum (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                consume,
  input  logic [7:0]          rx_byte,
  input  logic                last_byte,
  output dsfp_pkg::frame_sum_t sum
);
  import dsfp_pkg::*;

  logic [3:0]  idx_r,   idx_nxt;
  logic [7:0]  xor_r,   xor_nxt;
  logic        hdr_r,   hdr_nxt;
  logic [23:0] st_r,    st_nxt;
  logic        chk_r,   chk_nxt;
  logic [2:0]  pos;

  assign pos = idx_r[2:0];

  always_comb begin
    idx_nxt = idx_r;
    xor_nxt = xor_r;
    hdr_nxt = hdr_r;
    st_nxt  = st_r;
    chk_nxt = chk_r;
    if (idx_r < FRAME_LEN) begin
      if (pos != POS_CHK) xor_nxt = xor_r ^ rx_byte;
      if (pos == POS_S && rx_byte != CH_S) hdr_nxt = 1'b0;
      if (pos == POS_F && rx_byte != CH_F) hdr_nxt = 1'b0;
      if (pos == POS_ETX && rx_byte != CH_ETX) hdr_nxt = 1'b0;
      if (pos >= POS_ST0 && pos <= POS_ST2) st_nxt = {st_r[15:0], rx_byte};
      if (pos == POS_CHK) chk_nxt = (rx_byte == xor_r);
      idx_nxt = idx_r + 4'd1;
    end
  end

  assign sum.ok   = (idx_nxt == FRAME_LEN) && hdr_nxt && chk_nxt;
  assign sum.word = st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      xor_r <= '0;
      hdr_r <= 1'b1;
      st_r  <= '0;
      chk_r <= 1'b0;
    end else if (consume) begin
      if (last_byte) begin
        idx_r <= '0;
        xor_r <= '0;
        hdr_r <= 1'b1;
        st_r  <= '0;
        chk_r <= 1'b0;
      end else begin
        idx_r <= idx_nxt;
        xor_r <= xor_nxt;
        hdr_r <= hdr_nxt;
        st_r  <= st_nxt;
        chk_r <= chk_nxt;
      end
    end
  end

endmodule

/* sv/dsfp_out_stage.sv */
// ----------------------------------------------------------------------------
// dsfp_out_stage
// Result register: classifies the status word and holds the result until
// the downstream transfer.
// ----------------------------------------------------------------------------
module dsfp_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  dsfp_pkg::frame_sum_t sum,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_frame_ok,
  output logic [23:0]          out_status_word,
  output logic [3:0]           out_status_class
);
  import dsfp_pkg::*;

  logic        vld_r;
  logic        ok_r;
  logic [23:0] word_r;
  logic [3:0]  cls_r;

  assign free = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ok_r   <= sum.ok;
      word_r <= sum.ok ? sum.word : 24'd0;
      cls_r  <= sum.ok ? class_of(sum.word) : CLS_BAD;
    end
  end

  assign out_valid        = vld_r;
  assign out_frame_ok     = ok_r;
  assign out_status_word  = word_r;
  assign out_status_class = cls_r;

endmodule

/* sv/dispenser_status_frame_parser.sv */
// ----------------------------------------------------------------------------
// dispenser_status_frame_parser
// Checks an 8-byte dispenser reply burst and reports frame validity, the
// 24-bit status word and a dense status class on the final byte.
// ----------------------------------------------------------------------------
//  channel | ports                                   | dir
//  in      | in_valid/in_ready, in_rx_byte, in_last_byte | in
//  out     | out_valid/out_ready, out_frame_ok,           | out
//          | out_status_word, out_status_class            |
//
//  One byte per cycle while in_ready is high; input register, then frame
//  state update and result register. out_valid rises when the final byte
//  is loaded from the input register into the result register.
//  Reset (rst_n low, synchronous) clears both stages and the frame state.
//  A final byte waits in the input register while the result register is
//  full and not being taken, and in_ready stays low meanwhile; other bytes
//  pass through the input register without waiting.
// ----------------------------------------------------------------------------
module dispenser_status_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_frame_ok,
  output logic [23:0] out_status_word,
  output logic [3:0]  out_status_class
);
  import dsfp_pkg::*;

  logic       s1_vld_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_adv;
  logic       out_free;
  frame_sum_t sum;

  assign s1_adv   = s1_vld_r && (!s1_last_r || out_free);
  assign in_ready = !s1_vld_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_rx_byte;
      s1_last_r <= in_last_byte;
    end
  end

  dsfp_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .consume   (s1_adv),
    .rx_byte   (s1_byte_r),
    .last_byte (s1_last_r),
    .sum       (sum)
  );

  dsfp_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (s1_adv && s1_last_r),
    .sum              (sum),
    .free             (out_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_ok     (out_frame_ok),
    .out_status_word  (out_status_word),
    .out_status_class (out_status_class)
  );

endmodule

/* tb/dispenser_status_frame_parser_tb.sv */
// ----------------------------------------------------------------------------
// dispenser_status_frame_parser_tb
// Sends reply bursts to the parser one byte per transfer. The bursts are
// well-formed status frames, frames with a bad header, ETX or checksum,
// short and long bursts, and random noise. A byte-level model of the frame
// checker predicts each report, and every report is compared field by field
// with the oldest prediction. Sender gaps and receiver stalls change from
// phase to phase, and one long receiver hold-off backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dispenser_status_frame_parser_tb;
  import dsfp_pkg::*;

  typedef struct packed {
    logic [7:0] rx;
    logic       last;
  } reply_byte_t;

  typedef struct packed {
    logic        ok;
    logic [23:0] word;
    logic [3:0]  cls;
  } status_report_t;

  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PHASE_CYCLES = 300;
  localparam int unsigned HOLD_START   = 120;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 8;

  localparam int unsigned PHASE_FREE       = 0;
  localparam int unsigned PHASE_SEND_IDLE  = 1;
  localparam int unsigned PHASE_RECV_STALL = 2;
  localparam int unsigned PHASE_BOTH       = 3;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic [7:0]  in_rx_byte   = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_ready    = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_frame_ok;
  logic [23:0] out_status_word;
  logic [3:0]  out_status_class;

  logic [23:0] known_word [13] = '{
    24'h303030, 24'h303130, 24'h303430, 24'h313030, 24'h303830, 24'h303038,
    24'h303034, 24'h303032, 24'h303031, 24'h303230, 24'h383030, 24'h323030,
    24'h343030
  };
  logic [3:0] known_class [13] = '{
    CLS_READY, CLS_LOW_CARD, CLS_LOW_CARD, CLS_BIN_FULL, CLS_BIN_FULL, CLS_EMPTY,
    CLS_AT_EXIT, CLS_IN_READER, CLS_NOT_READY, CLS_BLOCKED, CLS_ISSUING,
    CLS_ISSUE_ERR, CLS_RETURNING
  };

  reply_byte_t    pending_q [$];
  status_report_t report_q [$];
  logic [7:0]     burst_q [$];

  logic [3:0]  byte_cnt    = 4'd0;
  logic [7:0]  running_xor = 8'h00;
  logic        hdr_ok      = 1'b1;
  logic [23:0] word_acc    = 24'h000000;
  logic        chk_ok      = 1'b0;

  int unsigned cycle_cnt  = 0;
  int unsigned hold_left  = 0;
  int unsigned item_total = 0;
  int unsigned errors     = 0;
  logic        in_xfer    = 1'b0;

  dispenser_status_frame_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_ok     (out_frame_ok),
    .out_status_word  (out_status_word),
    .out_status_class (out_status_class)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic [3:0] class_for_word(input logic [23:0] w);
    logic [3:0] c;
    c = CLS_BAD;
    for (int i = 0; i < 13; i++) begin
      if (known_word[i] == w) c = known_class[i];
    end
    return c;
  endfunction

  function automatic int unsigned idle_pct(input logic receiver);
    int unsigned ph;
    ph = (cycle_cnt / PHASE_CYCLES) % 4;
    if (ph == PHASE_FREE) return 0;
    if (ph == PHASE_BOTH) return 16;
    if (ph == PHASE_SEND_IDLE && !receiver) return 64;
    if (ph == PHASE_RECV_STALL && receiver) return 64;
    return 0;
  endfunction

  task automatic clear_frame_state();
    byte_cnt    = 4'd0;
    running_xor = 8'h00;
    hdr_ok      = 1'b1;
    word_acc    = 24'h000000;
    chk_ok      = 1'b0;
  endtask

  task automatic absorb_reply_byte(input reply_byte_t b);
    status_report_t r;
    if (byte_cnt < FRAME_LEN) begin
      if (byte_cnt[2:0] < POS_CHK) running_xor = running_xor ^ b.rx;
      if (byte_cnt[2:0] == POS_S && b.rx != CH_S) hdr_ok = 1'b0;
      if (byte_cnt[2:0] == POS_F && b.rx != CH_F) hdr_ok = 1'b0;
      if (byte_cnt[2:0] == POS_ETX && b.rx != CH_ETX) hdr_ok = 1'b0;
      if (byte_cnt[2:0] >= POS_ST0 && byte_cnt[2:0] <= POS_ST2)
        word_acc = {word_acc[15:0], b.rx};
      if (byte_cnt[2:0] == POS_CHK) chk_ok = (b.rx == running_xor);
      byte_cnt = byte_cnt + 4'd1;
    end
    if (b.last) begin
      r.ok   = (byte_cnt == FRAME_LEN) && hdr_ok && chk_ok;
      r.word = r.ok ? word_acc : 24'h000000;
      r.cls  = r.ok ? class_for_word(word_acc) : CLS_BAD;
      report_q.push_back(r);
      clear_frame_state();
    end
  endtask

  function automatic logic [23:0] pick_status_word();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return known_word[$urandom_range(0, 12)];
    if (r == 7) return ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
    return 24'($urandom());
  endfunction

  task automatic make_frame(input logic [7:0] lead, input logic [23:0] w);
    logic [7:0] x;
    burst_q.delete();
    burst_q.push_back(lead);
    burst_q.push_back(CH_S);
    burst_q.push_back(CH_F);
    burst_q.push_back(w[23:16]);
    burst_q.push_back(w[15:8]);
    burst_q.push_back(w[7:0]);
    burst_q.push_back(CH_ETX);
    x = 8'h00;
    foreach (burst_q[i]) x = x ^ burst_q[i];
    burst_q.push_back(x);
  endtask

  task automatic push_burst();
    reply_byte_t b;
    foreach (burst_q[i]) begin
      b.rx   = burst_q[i];
      b.last = (i == burst_q.size() - 1);
      pending_q.push_back(b);
    end
    item_total += burst_q.size();
  endtask

  task automatic queue_random_burst();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    make_frame(8'($urandom_range(0, 255)), pick_status_word());
    if (pick < 60) begin
    end else if (pick < 72) begin
      case ($urandom_range(0, 4))
        0: n = POS_S;
        1: n = POS_F;
        2: n = POS_ETX;
        3: n = POS_CHK;
        default: n = $urandom_range(0, 7);
      endcase
      burst_q[n] = burst_q[n] ^ 8'($urandom_range(1, 255));
    end else if (pick < 82) begin
      repeat ($urandom_range(1, 4)) burst_q.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 92) begin
      n = $urandom_range(1, 7);
      while (burst_q.size() > n) void'(burst_q.pop_back());
    end else begin
      burst_q.delete();
      repeat ($urandom_range(1, 12)) burst_q.push_back(8'($urandom_range(0, 255)));
    end
    push_burst();
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_xfer)) begin
      if (pending_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
        in_valid     <= 1'b1;
        in_rx_byte   <= pending_q[0].rx;
        in_last_byte <= pending_q[0].last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (cycle_cnt == HOLD_START) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(negedge clk) begin
    out_ready <= rst_n && hold_left == 0 && $urandom_range(0, 99) >= idle_pct(1'b1);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    status_report_t exp_r;
    in_xfer <= rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (report_q.size() == 0) begin
        $error("unexpected transfer: frame_ok %0d status_word %06h status_class %0d",
               out_frame_ok, out_status_word, out_status_class);
        errors++;
      end else begin
        exp_r = report_q.pop_front();
        if (out_frame_ok !== exp_r.ok) begin
          $error("frame_ok: expected %0d, got %0d", exp_r.ok, out_frame_ok);
          errors++;
        end
        if (out_status_word !== exp_r.word) begin
          $error("status_word: expected %06h, got %06h", exp_r.word, out_status_word);
          errors++;
        end
        if (out_status_class !== exp_r.cls) begin
          $error("status_class: expected %0d, got %0d", exp_r.cls, out_status_class);
          errors++;
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      absorb_reply_byte({in_rx_byte, in_last_byte});
      void'(pending_q.pop_front());
    end
  end

  initial begin
    int unsigned random_target;

    // alternate low card code, byte 0 at zero
    make_frame(8'h00, 24'h303430);
    push_burst();
    // one-byte burst
    burst_q = '{8'hFF};
    push_burst();
    // long burst, alternate bin full code, tail ignored
    make_frame(8'hFF, 24'h303830);
    burst_q.push_back(8'hFF);
    burst_q.push_back(8'h00);
    push_burst();
    burst_q = '{8'h00};
    push_burst();

    random_target = item_total + RANDOM_ITEMS;
    while (item_total < random_target) queue_random_burst();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || report_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
